// ===== hw/rtl/toi_pkg.sv =====
// ----------------------------------------------------------------------------
// toi_pkg
// Shared types, constants and helper functions for the tricycle odometry
// integrator: register indexes, command and status structs, the arctangent
// table of the CORDIC and fixed-point rounding helpers.
// ----------------------------------------------------------------------------
package toi_pkg;

  localparam int ANGLE_BITS_DEF    = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int POS_BITS_DEF      = 32;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 18;
  localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_RADIUS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_WHEELBASE = 1'd1;
  localparam logic [17:0] WHEEL_RADIUS_RST  = 18'd10813;
  localparam logic [17:0] INV_WHEELBASE_RST = 18'd43259;

  // CORDIC start vector, gain-compensated, Q1.30.
  localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
  localparam int TABLE_LEN = 24;

  // Turn conversion of the heading increment and microsecond scaling.
  localparam logic signed [20:0] TURN_RECIP = 21'sd699971;
  localparam logic signed [63:0] US_HALF    = 64'sd500000;
  localparam logic [20:0]        US_PER_S   = 21'd1000000;
  localparam logic signed [44:0] US_ROUND   = 45'sd999999;

  localparam int DIV_NW = 45;
  localparam int DIV_QB = 26;
  // Floor of 2^45 / 10^6; the quotient estimate from it is at most one low.
  localparam logic [DIV_QB-1:0] DIV_RECIP = 26'd35184372;

  localparam logic [31:0] ATAN_TURNS [TABLE_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef enum logic [3:0] {
    MOP_NONE, MOP_VW, MOP_V, MOP_T, MOP_W1, MOP_W2, MOP_P_COS, MOP_P_SIN,
    MOP_D1, MOP_D2, MOP_H1, MOP_H2, MOP_H3
  } mul_op_t;

  typedef enum logic [1:0] {
    CSRC_STEER, CSRC_HEAD, CSRC_QUAT
  } cordic_src_t;

  typedef enum logic {
    DSEL_X, DSEL_Y
  } div_sel_t;

  typedef struct packed {
    logic        in_load;
    mul_op_t     mop;
    logic        cordic_start;
    cordic_src_t cordic_src;
    logic        div_start;
    div_sel_t    div_sel;
    logic        out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic skip;
    logic cordic_done;
    logic div_done;
  } ctrl_stat_t;

  // Arctangent step of stage idx, rounded to ab bits of a turn.
  function automatic logic [23:0] atan_step(input logic [4:0] idx, input int ab);
    logic [32:0] t;
    t = {1'b0, ATAN_TURNS[idx]} + (33'd1 << (31 - ab));
    return 24'(t >> (32 - ab));
  endfunction

  // Round to nearest (ties up) after an arithmetic right shift, saturate to 24 bits.
  function automatic logic signed [23:0] rsat24(input logic signed [63:0] v, input int sh);
    logic signed [63:0] t;
    t = (v + (64'sd1 <<< (sh - 1))) >>> sh;
    if (t > 64'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (t < -64'sd8388608) begin
      return 24'sh800000;
    end
    return 24'(t);
  endfunction

endpackage

// ===== hw/rtl/tricycle_odometry_integrator.sv =====
// ----------------------------------------------------------------------------
// tricycle_odometry_integrator
// Dead-reckoning pose integrator for a vehicle with one steered drive wheel.
//
// Input channel (in_valid / in_stall): drive wheel rate, steering angle and
// elapsed microseconds. A transaction with zero elapsed time is taken and
// produces nothing. Any other transaction produces exactly one
// result on the output channel (out_valid / out_stall): saturated x and y,
// the new heading, the heading quaternion z and w, and the three speeds.
// One transaction is processed at a time, through three passes of the
// single iterative CORDIC, two divisions by one million and fourteen
// steps of the one shared multiplier.
// Results sit in an output register: while the receiver stalls, the next
// transaction is already accepted and computed, and it waits only at its end.
// Synchronous reset clears the pose, restores the default wheel radius and
// wheelbase reciprocal and empties the output register.
// cfg_we writes register cfg_index: 0 is wheel radius, 1 inverse wheelbase.
// ----------------------------------------------------------------------------
module tricycle_odometry_integrator #(
  parameter int ANGLE_BITS    = toi_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STAGES = toi_pkg::CORDIC_STAGES_DEF,
  parameter int POS_BITS      = toi_pkg::POS_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [23:0]              in_wheel_rate,
  input  logic signed [15:0]              in_steer_angle,
  input  logic [19:0]                     in_elapsed_us,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [31:0]              out_pos_x,
  output logic signed [31:0]              out_pos_y,
  output logic signed [15:0]              out_heading,
  output logic signed [15:0]              out_quat_z,
  output logic signed [15:0]              out_quat_w,
  output logic signed [23:0]              out_forward_speed,
  output logic signed [23:0]              out_yaw_rate,
  output logic signed [23:0]              out_wheel_speed,
  input  logic                            cfg_we,
  input  logic [toi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [toi_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import toi_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  toi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  toi_datapath #(
    .ANGLE_BITS    (ANGLE_BITS),
    .CORDIC_STAGES (CORDIC_STAGES),
    .POS_BITS      (POS_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_wheel_rate     (in_wheel_rate),
    .in_steer_angle    (in_steer_angle),
    .in_elapsed_us     (in_elapsed_us),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_pos_x         (out_pos_x),
    .out_pos_y         (out_pos_y),
    .out_heading       (out_heading),
    .out_quat_z        (out_quat_z),
    .out_quat_w        (out_quat_w),
    .out_forward_speed (out_forward_speed),
    .out_yaw_rate      (out_yaw_rate),
    .out_wheel_speed   (out_wheel_speed)
  );

endmodule

// ===== hw/rtl/toi_cordic.sv =====
// ----------------------------------------------------------------------------
// toi_cordic
// Iterative rotation-mode CORDIC, one stage per cycle. Takes an angle in
// units of 2^-17 turn and returns rounded, saturated Q1.15 sine and cosine.
// ----------------------------------------------------------------------------
module toi_cordic #(
  parameter int ANGLE_BITS    = toi_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STAGES = toi_pkg::CORDIC_STAGES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [16:0]         angle,
  output logic                done,
  output logic signed [15:0]  sin_q,
  output logic signed [15:0]  cos_q
);
  import toi_pkg::*;

  localparam int AW = ANGLE_BITS + 2;
  localparam int CW = $clog2(CORDIC_STAGES);

  logic signed [33:0]    x_r, y_r;
  logic signed [AW-1:0]  z_r;
  logic [CW-1:0]         cnt_r;
  logic                  busy_r, fin_r, flip_r;

  logic [40:0]            ext;
  logic [ANGLE_BITS-1:0]  a0, a1;
  logic                   fold;
  logic [23:0]            stp;
  logic signed [AW-1:0]   stepz;
  logic signed [33:0]     dxs, dys, cr, sr;

  always_comb begin
    ext   = {angle, 24'd0};
    a0    = ext[40:41-ANGLE_BITS];
    fold  = (a0[ANGLE_BITS-1:ANGLE_BITS-2] == 2'b01) ||
            (a0[ANGLE_BITS-1:ANGLE_BITS-2] == 2'b10);
    // Adding a half turn only flips the top bit.
    a1    = fold ? {~a0[ANGLE_BITS-1], a0[ANGLE_BITS-2:0]} : a0;
    stp   = atan_step(5'(cnt_r), ANGLE_BITS);
    stepz = {2'b00, stp[ANGLE_BITS-1:0]};
    dxs   = y_r >>> cnt_r;
    dys   = x_r >>> cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      fin_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CW'(CORDIC_STAGES - 1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= CORDIC_X0;
      y_r    <= '0;
      z_r    <= {{2{a1[ANGLE_BITS-1]}}, a1};
      flip_r <= fold;
    end else if (busy_r) begin
      if (z_r[AW-1]) begin
        x_r <= x_r + dxs;
        y_r <= y_r - dys;
        z_r <= z_r + stepz;
      end else begin
        x_r <= x_r - dxs;
        y_r <= y_r + dys;
        z_r <= z_r - stepz;
      end
    end
  end

  always_comb begin
    cr = (x_r + 34'sd16384) >>> 15;
    sr = (y_r + 34'sd16384) >>> 15;
    if (flip_r) begin
      cr = -cr;
      sr = -sr;
    end
    if (cr > 34'sd32767) cos_q = 16'sh7FFF;
    else if (cr < -34'sd32768) cos_q = 16'sh8000;
    else cos_q = 16'(cr);
    if (sr > 34'sd32767) sin_q = 16'sh7FFF;
    else if (sr < -34'sd32768) sin_q = 16'sh8000;
    else sin_q = 16'(sr);
  end

  assign done = fin_r;

endmodule

// ===== hw/rtl/toi_div.sv =====
// ----------------------------------------------------------------------------
// toi_div
// Floor division by one million through a reciprocal multiplication and one
// compare-and-subtract correction.
// ----------------------------------------------------------------------------
module toi_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic signed [44:0]              num,
  output logic                            done,
  output logic signed [toi_pkg::DIV_QB:0] quo
);
  import toi_pkg::*;

  logic [DIV_NW-1:0]  mag_r;
  logic               neg_r, fin_r;
  logic [3:0]         stg_r;
  logic [51:0]        p1_r;
  logic [DIV_QB-1:0]  q0_r, q_r;
  logic [46:0]        p2_r;

  logic [DIV_NW-1:0]  mag;
  logic [DIV_NW-1:0]  rem;

  always_comb begin
    // Floor of a negative quotient is minus the ceiling of the magnitude.
    mag = num[44] ? DIV_NW'(US_ROUND - num) : DIV_NW'(num);
    rem = mag_r - p2_r[DIV_NW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r <= '0;
      fin_r <= 1'b0;
    end else begin
      stg_r <= {stg_r[2:0], start};
      fin_r <= stg_r[3];
    end
  end

  // The estimate from the top 26 bits never exceeds the true quotient and
  // falls short by at most one, so a single compare finishes it.
  always_ff @(posedge clk) begin
    if (start) begin
      mag_r <= mag;
      neg_r <= num[44];
    end
    p1_r <= mag_r[DIV_NW-1:DIV_NW-DIV_QB] * DIV_RECIP;
    q0_r <= p1_r[51:26];
    p2_r <= q0_r * US_PER_S;
    q_r  <= (rem >= DIV_NW'(US_PER_S)) ? q0_r + 1'b1 : q0_r;
  end

  assign done = fin_r;
  assign quo  = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});

endmodule

// ===== hw/rtl/toi_datapath.sv =====
// ----------------------------------------------------------------------------
// toi_datapath
// Operand registers, shared multiplier with accumulator, CORDIC and divider,
// pose state and result registers of the odometry integrator.
// ----------------------------------------------------------------------------
module toi_datapath #(
  parameter int ANGLE_BITS    = toi_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STAGES = toi_pkg::CORDIC_STAGES_DEF,
  parameter int POS_BITS      = toi_pkg::POS_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  toi_pkg::ctrl_cmd_t              cmd,
  output toi_pkg::ctrl_stat_t             stat,
  input  logic signed [23:0]              in_wheel_rate,
  input  logic signed [15:0]              in_steer_angle,
  input  logic [19:0]                     in_elapsed_us,
  input  logic                            cfg_we,
  input  logic [toi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [toi_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic signed [31:0]              out_pos_x,
  output logic signed [31:0]              out_pos_y,
  output logic signed [15:0]              out_heading,
  output logic signed [15:0]              out_quat_z,
  output logic signed [15:0]              out_quat_w,
  output logic signed [23:0]              out_forward_speed,
  output logic signed [23:0]              out_yaw_rate,
  output logic signed [23:0]              out_wheel_speed
);
  import toi_pkg::*;

  localparam int SW = ((POS_BITS > DIV_QB + 1) ? POS_BITS : DIV_QB + 1) + 1;
  localparam int OW = (POS_BITS > 32) ? POS_BITS : 32;
  localparam logic signed [SW-1:0] P_HI = SW'((64'sd1 <<< (POS_BITS - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] P_LO = -P_HI - SW'(1);
  localparam logic signed [OW-1:0] O_HI = OW'(64'sd2147483647);
  localparam logic signed [OW-1:0] O_LO = -O_HI - OW'(1);

  logic [17:0]               radius_r, inv_wb_r;
  logic signed [23:0]        rate_r;
  logic [15:0]               steer_r;
  logic [19:0]               us_r;

  logic signed [15:0]        sin_st_r, cos_st_r, sin_h_r, cos_h_r, qz_r, qw_r;
  logic signed [23:0]        vw_r, v_r, w_r;
  logic [40:0]               t_r;
  logic [39:0]               p_r;
  logic [43:0]               q_r;
  logic signed [44:0]        div_n_r;

  logic signed [POS_BITS-1:0] x_acc_r, y_acc_r;
  logic [15:0]               head_r;

  logic signed [25:0]        mul_a;
  logic signed [20:0]        mul_b;
  logic signed [46:0]        prod_r;
  mul_op_t                   pop_r, pop2_r;
  logic signed [63:0]        acc_r, acc_nxt, p64, hround;

  cordic_src_t               csrc_r;
  div_sel_t                  dsel_r;
  logic [16:0]               c_angle;
  logic                      c_done, d_done;
  logic signed [15:0]        c_sin, c_cos;
  logic signed [DIV_QB:0]    d_quo;
  logic signed [SW-1:0]      pos_sum, pos_sat;
  logic signed [OW-1:0]      xe, ye;

  assign stat.skip        = (in_elapsed_us == 20'd0);
  assign stat.cordic_done = c_done;
  assign stat.div_done    = d_done;

  always_comb begin
    case (cmd.cordic_src)
      CSRC_STEER: c_angle = {steer_r, 1'b0};
      CSRC_HEAD:  c_angle = {head_r, 1'b0};
      CSRC_QUAT:  c_angle = {head_r[15], head_r};
      default:    c_angle = '0;
    endcase
  end

  toi_cordic #(
    .ANGLE_BITS    (ANGLE_BITS),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.cordic_start),
    .angle (c_angle),
    .done  (c_done),
    .sin_q (c_sin),
    .cos_q (c_cos)
  );

  toi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_n_r),
    .done  (d_done),
    .quo   (d_quo)
  );

  // Operand selection of the shared multiplier. Wide products are split
  // into a signed upper part and an unsigned lower part.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mop)
      MOP_VW: begin
        mul_a = 26'(rate_r);
        mul_b = {3'b000, radius_r};
      end
      MOP_V: begin
        mul_a = 26'(vw_r);
        mul_b = 21'(cos_st_r);
      end
      MOP_T: begin
        mul_a = 26'(vw_r);
        mul_b = -21'(sin_st_r);
      end
      MOP_W1: begin
        mul_a = 26'($signed(t_r[40:24]));
        mul_b = {3'b000, inv_wb_r};
      end
      MOP_W2: begin
        mul_a = {2'b00, t_r[23:0]};
        mul_b = {3'b000, inv_wb_r};
      end
      MOP_P_COS: begin
        mul_a = 26'(v_r);
        mul_b = 21'(cos_h_r);
      end
      MOP_P_SIN: begin
        mul_a = 26'(v_r);
        mul_b = 21'(sin_h_r);
      end
      MOP_D1: begin
        mul_a = 26'($signed(p_r[39:20]));
        mul_b = {1'b0, us_r};
      end
      MOP_D2: begin
        mul_a = {6'd0, p_r[19:0]};
        mul_b = {1'b0, us_r};
      end
      MOP_H1: begin
        mul_a = 26'(w_r);
        mul_b = {1'b0, us_r};
      end
      MOP_H2: begin
        mul_a = 26'($signed(q_r[43:24]));
        mul_b = TURN_RECIP;
      end
      MOP_H3: begin
        mul_a = {2'b00, q_r[23:0]};
        mul_b = TURN_RECIP;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    p64 = 64'(prod_r);
    case (pop_r)
      MOP_NONE:                acc_nxt = acc_r;
      MOP_W1, MOP_H2:          acc_nxt = p64 <<< 24;
      MOP_D1:                  acc_nxt = p64 <<< 20;
      MOP_W2, MOP_D2, MOP_H3:  acc_nxt = acc_r + p64;
      default:                 acc_nxt = p64;
    endcase
    hround = acc_r + (64'sd1 <<< 41);
  end

  always_comb begin
    pos_sum = (dsel_r == DSEL_X) ? SW'(x_acc_r) + SW'(d_quo) : SW'(y_acc_r) + SW'(d_quo);
    if (pos_sum > P_HI) pos_sat = P_HI;
    else if (pos_sum < P_LO) pos_sat = P_LO;
    else pos_sat = pos_sum;
    xe = OW'(x_acc_r);
    ye = OW'(y_acc_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= WHEEL_RADIUS_RST;
      inv_wb_r <= INV_WHEELBASE_RST;
      pop_r    <= MOP_NONE;
      pop2_r   <= MOP_NONE;
      x_acc_r  <= '0;
      y_acc_r  <= '0;
      head_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WHEEL_RADIUS:  radius_r <= cfg_data;
          CFG_INV_WHEELBASE: inv_wb_r <= cfg_data;
          default: ;
        endcase
      end
      pop_r  <= cmd.mop;
      pop2_r <= pop_r;
      if (d_done) begin
        if (dsel_r == DSEL_X) x_acc_r <= POS_BITS'(pos_sat);
        else y_acc_r <= POS_BITS'(pos_sat);
      end
      if (pop2_r == MOP_H3) begin
        head_r <= head_r + hround[57:42];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      rate_r  <= in_wheel_rate;
      steer_r <= in_steer_angle;
      us_r    <= in_elapsed_us;
    end
    if (cmd.cordic_start) csrc_r <= cmd.cordic_src;
    if (cmd.div_start) dsel_r <= cmd.div_sel;
    prod_r <= mul_a * mul_b;
    acc_r  <= acc_nxt;
    case (pop2_r)
      MOP_VW:               vw_r <= rsat24(acc_r, 16);
      MOP_V:                v_r <= rsat24(acc_r, 15);
      MOP_T:                t_r <= acc_r[40:0];
      MOP_W2:               w_r <= rsat24(acc_r, 31);
      MOP_P_COS, MOP_P_SIN: p_r <= acc_r[39:0];
      MOP_D2:               div_n_r <= 45'((acc_r >>> 15) + US_HALF);
      MOP_H1:               q_r <= acc_r[43:0];
      default: ;
    endcase
    if (c_done) begin
      case (csrc_r)
        CSRC_STEER: begin
          sin_st_r <= c_sin;
          cos_st_r <= c_cos;
        end
        CSRC_HEAD: begin
          sin_h_r <= c_sin;
          cos_h_r <= c_cos;
        end
        CSRC_QUAT: begin
          qz_r <= c_sin;
          qw_r <= c_cos;
        end
        default: ;
      endcase
    end
    if (cmd.out_load) begin
      out_pos_x         <= (xe > O_HI) ? 32'sh7FFFFFFF : ((xe < O_LO) ? 32'sh80000000 : 32'(xe));
      out_pos_y         <= (ye > O_HI) ? 32'sh7FFFFFFF : ((ye < O_LO) ? 32'sh80000000 : 32'(ye));
      out_heading       <= head_r;
      out_quat_z        <= qz_r;
      out_quat_w        <= qw_r;
      out_forward_speed <= v_r;
      out_yaw_rate      <= w_r;
      out_wheel_speed   <= vw_r;
    end
  end

endmodule

// ===== hw/rtl/toi_ctrl.sv =====
// ----------------------------------------------------------------------------
// toi_ctrl
// Sequencer of the odometry integrator: steps the shared multiplier, the
// CORDIC and the divider through one update and handles both handshakes.
// ----------------------------------------------------------------------------
module toi_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  toi_pkg::ctrl_stat_t  stat,
  output toi_pkg::ctrl_cmd_t   cmd
);
  import toi_pkg::*;

  typedef enum logic [20:0] {
    S_IDLE = 21'd1 << 0,
    S_VW   = 21'd1 << 1,
    S_CS   = 21'd1 << 2,
    S_V    = 21'd1 << 3,
    S_T    = 21'd1 << 4,
    S_W1   = 21'd1 << 5,
    S_W2   = 21'd1 << 6,
    S_CH   = 21'd1 << 7,
    S_PX   = 21'd1 << 8,
    S_DX1  = 21'd1 << 9,
    S_DX2  = 21'd1 << 10,
    S_DVX  = 21'd1 << 11,
    S_PY   = 21'd1 << 12,
    S_DY1  = 21'd1 << 13,
    S_DY2  = 21'd1 << 14,
    S_DVY  = 21'd1 << 15,
    S_H1   = 21'd1 << 16,
    S_H2   = 21'd1 << 17,
    S_H3   = 21'd1 << 18,
    S_CQ   = 21'd1 << 19,
    S_DONE = 21'd1 << 20
  } state_t;

  state_t      state_r, state_nxt, follow;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        k_mul, k_cor, k_div;
  mul_op_t     mop_sel;

  always_comb begin
    cmd          = '0;
    cmd.mop      = MOP_NONE;
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    follow       = S_IDLE;
    k_mul        = 1'b0;
    k_cor        = 1'b0;
    k_div        = 1'b0;
    mop_sel      = MOP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.in_load = 1'b1;
          // A transaction with no elapsed time leaves the pose alone.
          if (!stat.skip) state_nxt = S_VW;
        end
      end
      S_VW:  begin k_mul = 1'b1; mop_sel = MOP_VW;    follow = S_CS;  end
      S_CS:  begin k_cor = 1'b1; cmd.cordic_src = CSRC_STEER; follow = S_V; end
      S_V:   begin k_mul = 1'b1; mop_sel = MOP_V;     follow = S_T;   end
      S_T:   begin k_mul = 1'b1; mop_sel = MOP_T;     follow = S_W1;  end
      S_W1:  begin k_mul = 1'b1; mop_sel = MOP_W1;    follow = S_W2;  end
      S_W2:  begin k_mul = 1'b1; mop_sel = MOP_W2;    follow = S_CH;  end
      S_CH:  begin k_cor = 1'b1; cmd.cordic_src = CSRC_HEAD; follow = S_PX; end
      S_PX:  begin k_mul = 1'b1; mop_sel = MOP_P_COS; follow = S_DX1; end
      S_DX1: begin k_mul = 1'b1; mop_sel = MOP_D1;    follow = S_DX2; end
      S_DX2: begin k_mul = 1'b1; mop_sel = MOP_D2;    follow = S_DVX; end
      S_DVX: begin k_div = 1'b1; cmd.div_sel = DSEL_X; follow = S_PY; end
      S_PY:  begin k_mul = 1'b1; mop_sel = MOP_P_SIN; follow = S_DY1; end
      S_DY1: begin k_mul = 1'b1; mop_sel = MOP_D1;    follow = S_DY2; end
      S_DY2: begin k_mul = 1'b1; mop_sel = MOP_D2;    follow = S_DVY; end
      S_DVY: begin k_div = 1'b1; cmd.div_sel = DSEL_Y; follow = S_H1; end
      S_H1:  begin k_mul = 1'b1; mop_sel = MOP_H1;    follow = S_H2;  end
      S_H2:  begin k_mul = 1'b1; mop_sel = MOP_H2;    follow = S_H3;  end
      S_H3:  begin k_mul = 1'b1; mop_sel = MOP_H3;    follow = S_CQ;  end
      S_CQ:  begin k_cor = 1'b1; cmd.cordic_src = CSRC_QUAT; follow = S_DONE; end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // A multiply step issues once, then waits for the product, the
    // accumulation and the rescaled result to settle.
    if (k_mul) begin
      if (cnt_r == 2'd0) cmd.mop = mop_sel;
      if (cnt_r == 2'd2) begin
        state_nxt = follow;
        cnt_nxt   = 2'd0;
      end else begin
        cnt_nxt = cnt_r + 2'd1;
      end
    end
    if (k_cor || k_div) begin
      if (cnt_r == 2'd0) begin
        cmd.cordic_start = k_cor;
        cmd.div_start    = k_div;
        cnt_nxt          = 2'd1;
      end else if ((k_cor && stat.cordic_done) || (k_div && stat.div_done)) begin
        state_nxt = follow;
        cnt_nxt   = 2'd0;
      end
    end

    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule
